@@ src/bgpl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_pkg: shared types, tables and helpers for the battery gauge
// Holds the two piecewise-linear tables, command and status types.
// ----------------------------------------------------------------------------
package bgpl_pkg;

	localparam int ADC_W = 12;
	localparam int CFG_W = 11;
	localparam int CELLS_W = 4;
	localparam int MV_W = 15;
	localparam int CHG_W = 10;

	localparam int PACK_POINTS = 14;
	localparam int CELL_POINTS = 12;
	localparam int IDX_W = 4;
	localparam int X_W = 15;
	localparam int Y_W = 15;
	// largest segment width in x and rise in y over both tables
	localparam int DX_W = 12;
	localparam int DY_W = 13;
	localparam int PROD_W = 22;

	localparam logic [CFG_W-1:0] SPR_RESET = 11'd1000;
	localparam logic [CELLS_W-1:0] CELLS_RESET = 4'd7;

	localparam logic CFG_SPR = 1'b0;
	localparam logic CFG_CELLS = 1'b1;

	localparam logic [X_W-1:0] PACK_X [PACK_POINTS] = '{
		15'd1732, 15'd2418, 15'd2509, 15'd2600, 15'd2753, 15'd2853, 15'd2889,
		15'd2909, 15'd2936, 15'd2951, 15'd3005, 15'd3068, 15'd3090, 15'd3122};
	localparam logic [Y_W-1:0] PACK_Y [PACK_POINTS] = '{
		15'd14010, 15'd20000, 15'd21000, 15'd22000, 15'd24000, 15'd25470, 15'd26000,
		15'd26400, 15'd26840, 15'd27000, 15'd28000, 15'd29050, 15'd29400, 15'd30000};
	localparam logic [X_W-1:0] CELL_X [CELL_POINTS] = '{
		15'd3000, 15'd3450, 15'd3680, 15'd3740, 15'd3770, 15'd3790,
		15'd3820, 15'd3870, 15'd3920, 15'd3980, 15'd4060, 15'd4200};
	localparam logic [Y_W-1:0] CELL_Y [CELL_POINTS] = '{
		15'd0, 15'd50, 15'd100, 15'd200, 15'd300, 15'd400,
		15'd500, 15'd600, 15'd700, 15'd800, 15'd900, 15'd1000};

	typedef enum logic {TBL_PACK, TBL_CELL} tbl_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACC,
		OP_AVG_DONE,
		OP_SEARCH,
		OP_LATCH_Y,
		OP_PACK_DONE,
		OP_CELL_DONE,
		OP_CHG_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic clamp;
		logic seg;
		tbl_t tsel;
	} stat_t;

	function automatic logic [IDX_W-1:0] tbl_last(tbl_t t);
		logic [IDX_W-1:0] r;
		case (t)
			TBL_PACK: r = IDX_W'(PACK_POINTS - 1);
			TBL_CELL: r = IDX_W'(CELL_POINTS - 1);
			default:  r = IDX_W'(PACK_POINTS - 1);
		endcase
		return r;
	endfunction

	function automatic logic [X_W-1:0] tbl_x(tbl_t t, logic [IDX_W-1:0] i);
		logic [X_W-1:0] r;
		case (t)
			TBL_PACK: r = (i < IDX_W'(PACK_POINTS)) ? PACK_X[i] : PACK_X[PACK_POINTS-1];
			TBL_CELL: r = (i < IDX_W'(CELL_POINTS)) ? CELL_X[i] : CELL_X[CELL_POINTS-1];
			default:  r = PACK_X[0];
		endcase
		return r;
	endfunction

	function automatic logic [Y_W-1:0] tbl_y(tbl_t t, logic [IDX_W-1:0] i);
		logic [Y_W-1:0] r;
		case (t)
			TBL_PACK: r = (i < IDX_W'(PACK_POINTS)) ? PACK_Y[i] : PACK_Y[PACK_POINTS-1];
			TBL_CELL: r = (i < IDX_W'(CELL_POINTS)) ? CELL_Y[i] : CELL_Y[CELL_POINTS-1];
			default:  r = PACK_Y[0];
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/bgpl_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_in_if: sample channel
// Valid/ready channel carrying one raw ADC sample per transfer.
// ----------------------------------------------------------------------------
interface bgpl_in_if
	import bgpl_pkg::*;
;
	logic valid;
	logic ready;
	logic [ADC_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface
`default_nettype wire

@@ src/bgpl_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_out_if: reading channel
// Valid/ready channel carrying one finished gauge reading per transfer.
// ----------------------------------------------------------------------------
interface bgpl_out_if
	import bgpl_pkg::*;
;
	logic valid;
	logic ready;
	logic [ADC_W-1:0] average_adc;
	logic [MV_W-1:0] battery_millivolts;
	logic [MV_W-1:0] cell_millivolts;
	logic [CHG_W-1:0] charge_tenths_percent;

	modport source (output valid, output average_adc, output battery_millivolts,
		output cell_millivolts, output charge_tenths_percent, input ready);
	modport sink (input valid, input average_adc, input battery_millivolts,
		input cell_millivolts, input charge_tenths_percent, output ready);
endinterface
`default_nettype wire

@@ src/bgpl_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_div: shared restoring divider
// Unsigned, one quotient bit per cycle; done pulses once the quotient is ready.
// ----------------------------------------------------------------------------
module bgpl_div #(
	parameter int DVD_W = 23,
	parameter int DVS_W = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DVD_W-1:0] dividend,
	input wire logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic done
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] shifted;
	logic [DVS_W:0] diff;
	logic ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff = shifted - {1'b0, den_q};
	assign ge = ~diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

@@ src/bgpl_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_dp: gauge datapath
// Sample accumulator, table segment search, interpolation and output registers.
// ----------------------------------------------------------------------------
module bgpl_dp
	import bgpl_pkg::*;
#(
	parameter int CNT_W = 11,
	parameter int DVD_W = 23,
	parameter int DVS_W = 11
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output stat_t stat,
	input wire logic [CNT_W-1:0] target,
	input wire logic [CELLS_W-1:0] cells,
	input wire logic [ADC_W-1:0] adc_sample,
	output logic [ADC_W-1:0] average_adc,
	output logic [MV_W-1:0] battery_millivolts,
	output logic [MV_W-1:0] cell_millivolts,
	output logic [CHG_W-1:0] charge_tenths_percent
);
	localparam int SUM_W = CNT_W + ADC_W;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] taken_q;
	logic [ADC_W-1:0] avg_q;
	logic [MV_W-1:0] pack_q;
	logic [MV_W-1:0] cell_q;
	logic [X_W-1:0] x_q;
	logic [IDX_W-1:0] idx_q;
	tbl_t tsel_q;
	logic [Y_W-1:0] lo_q;
	logic [Y_W-1:0] y_q;
	logic [ADC_W-1:0] avg_out_q;
	logic [MV_W-1:0] pack_out_q;
	logic [MV_W-1:0] cell_out_q;
	logic [CHG_W-1:0] chg_out_q;

	logic [SUM_W-1:0] sum_next;
	logic last;
	logic [X_W-1:0] x_first, x_end, x_lo, x_hi;
	logic [Y_W-1:0] y_lo, y_hi;
	logic clamp_lo, clamp_hi, clamp, seg;
	logic [DX_W-1:0] dx;
	logic [DY_W-1:0] dy;
	logic [DX_W+DY_W-1:0] prod;
	logic div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DVD_W-1:0] quot;
	logic div_done;
	logic [ADC_W-1:0] avg_clamped;
	logic [CELLS_W-1:0] cells_fix;

	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign last = ({1'b0, taken_q} + 1'b1) >= {1'b0, target};
	assign cells_fix = (cells == '0) ? CELLS_W'(1) : cells;

	assign x_first = tbl_x(tsel_q, '0);
	assign x_end = tbl_x(tsel_q, tbl_last(tsel_q));
	assign x_lo = tbl_x(tsel_q, idx_q - 1'b1);
	assign x_hi = tbl_x(tsel_q, idx_q);
	assign y_lo = tbl_y(tsel_q, idx_q - 1'b1);
	assign y_hi = tbl_y(tsel_q, idx_q);
	assign clamp_lo = x_q <= x_first;
	assign clamp_hi = x_q >= x_end;
	assign clamp = clamp_lo | clamp_hi;
	assign seg = ~clamp & (x_q <= x_hi);

	assign dx = DX_W'(x_q - x_lo);
	assign dy = DY_W'(y_hi - y_lo);
	assign prod = dx * dy;

	assign avg_clamped = (quot > DVD_W'({ADC_W{1'b1}})) ? {ADC_W{1'b1}} : quot[ADC_W-1:0];

	always_comb begin
		div_start = 1'b0;
		div_dvd = DVD_W'(sum_next);
		div_dvs = DVS_W'(target);
		case (cmd.op)
			OP_ACC: begin
				div_start = last;
			end
			OP_SEARCH: begin
				div_start = seg;
				div_dvd = DVD_W'(prod[PROD_W-1:0]);
				div_dvs = DVS_W'(x_hi - x_lo);
			end
			OP_PACK_DONE: begin
				div_start = 1'b1;
				div_dvd = DVD_W'(y_q);
				div_dvs = DVS_W'(cells_fix);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bgpl_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.quotient(quot),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			taken_q <= '0;
			tsel_q <= TBL_PACK;
		end else begin
			case (cmd.op)
				OP_ACC: begin
					if (last) begin
						sum_q <= '0;
						taken_q <= '0;
					end else begin
						sum_q <= sum_next;
						taken_q <= taken_q + 1'b1;
					end
				end
				OP_AVG_DONE: tsel_q <= TBL_PACK;
				OP_CELL_DONE: tsel_q <= TBL_CELL;
				default: begin
					tsel_q <= tsel_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_AVG_DONE: begin
				avg_q <= avg_clamped;
				x_q <= X_W'(avg_clamped);
				idx_q <= IDX_W'(1);
			end
			OP_SEARCH: begin
				if (clamp) begin
					y_q <= clamp_lo ? tbl_y(tsel_q, '0) : tbl_y(tsel_q, tbl_last(tsel_q));
				end else if (seg) begin
					lo_q <= y_lo;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			OP_LATCH_Y: y_q <= lo_q + quot[Y_W-1:0];
			OP_PACK_DONE: pack_q <= y_q;
			OP_CELL_DONE: begin
				cell_q <= quot[MV_W-1:0];
				x_q <= quot[X_W-1:0];
				idx_q <= IDX_W'(1);
			end
			OP_CHG_DONE: begin
				avg_out_q <= avg_q;
				pack_out_q <= pack_q;
				cell_out_q <= cell_q;
				chg_out_q <= y_q[CHG_W-1:0];
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign stat.last = last;
	assign stat.div_done = div_done;
	assign stat.clamp = clamp;
	assign stat.seg = seg;
	assign stat.tsel = tsel_q;

	assign average_adc = avg_out_q;
	assign battery_millivolts = pack_out_q;
	assign cell_millivolts = cell_out_q;
	assign charge_tenths_percent = chg_out_q;
endmodule
`default_nettype wire

@@ src/bgpl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bgpl_ctrl: gauge controller
// Sequences accumulation, averaging, both table lookups and the output transfer.
// ----------------------------------------------------------------------------
module bgpl_ctrl
	import bgpl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output cmd_t cmd,
	input wire stat_t stat
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_SRCH,
		ST_IDIV,
		ST_POST,
		ST_CDIV
	} state_t;

	state_t state_q;
	logic out_valid_q;

	always_comb begin
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = ~out_valid_q | out_ready | ~stat.last;
				cmd.op = (in_valid & in_ready) ? OP_ACC : OP_NONE;
			end
			ST_AVG: cmd.op = stat.div_done ? OP_AVG_DONE : OP_NONE;
			ST_SRCH: cmd.op = OP_SEARCH;
			ST_IDIV: cmd.op = stat.div_done ? OP_LATCH_Y : OP_NONE;
			ST_POST: cmd.op = (stat.tsel == TBL_PACK) ? OP_PACK_DONE : OP_CHG_DONE;
			ST_CDIV: cmd.op = stat.div_done ? OP_CELL_DONE : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready && stat.last) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (stat.div_done) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (stat.clamp) begin
						state_q <= ST_POST;
					end else if (stat.seg) begin
						state_q <= ST_IDIV;
					end
				end
				ST_IDIV: begin
					if (stat.div_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (stat.tsel == TBL_PACK) begin
						state_q <= ST_CDIV;
					end else begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_CDIV: begin
					if (stat.div_done) begin
						state_q <= ST_SRCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

@@ src/battery_gauge_piecewise_linear_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_piecewise_linear_top: ADC battery gauge
// Averages ADC samples and maps the mean to pack mV, cell mV and charge.
// ----------------------------------------------------------------------------
// A sample is taken on each transfer while the gauge is accumulating. The sample
// that completes a reading starts a sequence on one shared restoring divider
// (one quotient bit per cycle): the average, the pack interpolation, the
// division by cell count and the cell interpolation, each lookup preceded
// by a one-index-per-cycle segment scan. No sample is taken while a completed
// reading is worked through, whether both lookups clamp at a table end or land
// in a segment. The finished reading sits in an output register; samples
// keep flowing until the next completing sample, which waits for that transfer.
// ----------------------------------------------------------------------------
module battery_gauge_piecewise_linear_top
	import bgpl_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	bgpl_in_if.sink in_ch,
	bgpl_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = CNT_W + ADC_W;
	localparam int DVD_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int DVS_W = (CNT_W > 10) ? CNT_W : 10;

	logic [CFG_W-1:0] spr_q;
	logic [CELLS_W-1:0] cells_q;
	logic [CFG_W-1:0] spr_fix;
	logic [CNT_W-1:0] target;
	cmd_t cmd;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= SPR_RESET;
			cells_q <= CELLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPR: spr_q <= cfg_data;
				CFG_CELLS: cells_q <= cfg_data[CELLS_W-1:0];
				default: spr_q <= spr_q;
			endcase
		end
	end

	assign spr_fix = (spr_q == '0) ? CFG_W'(1) : spr_q;
	assign target = (32'(spr_fix) > MAX_SAMPLES) ? CNT_W'(MAX_SAMPLES) : CNT_W'(spr_fix);

	bgpl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd(cmd),
		.stat(stat)
	);

	bgpl_dp #(
		.CNT_W(CNT_W),
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.target(target),
		.cells(cells_q),
		.adc_sample(in_ch.adc_sample),
		.average_adc(out_ch.average_adc),
		.battery_millivolts(out_ch.battery_millivolts),
		.cell_millivolts(out_ch.cell_millivolts),
		.charge_tenths_percent(out_ch.charge_tenths_percent)
	);
endmodule
`default_nettype wire
